@@ sv/fermion_term_apply_lookup_macros.svh @@
// Assertion helpers for the fermion_term_apply_lookup module
`ifndef FERMION_TERM_APPLY_LOOKUP_MACROS_SVH
`define FERMION_TERM_APPLY_LOOKUP_MACROS_SVH

// Assert that an antecedent implies a consequent on the next clock edge
`define FTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Assert that a condition holds at every clock edge outside reset
`define FTA_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

`endif

@@ sv/fta_pkg.sv @@
package fta_pkg;

   localparam int MAX_ROWS  = 1024;
   localparam int MAX_SITES = 64;
   localparam int SLOTS     = 4;
   localparam int ROW_W     = $clog2(MAX_ROWS);
   localparam int CNT_W     = $clog2(MAX_ROWS + 1);
   localparam int SITE_W    = 6;
   localparam int SCNT_W    = 7;

   typedef logic [1:0] act_type;
   localparam act_type ACT_EMPTY = 2'd0;
   localparam act_type ACT_ANNIH = 2'd1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_APPLY = 1'b1;

   localparam logic CSR_OUTSIDE    = 1'b0;
   localparam logic CSR_SITE_COUNT = 1'b1;

   // Memory access request toward the row store
   typedef struct packed {
      logic              rd_en;
      logic [ROW_W-1:0]  rd_addr;
      logic              wr_en;
      logic [ROW_W-1:0]  wr_addr;
      logic [63:0]       wr_data;
   } mem_req_type;

   // Apply one ladder operator; returns {fail, parity, new vector}
   function automatic logic [65:0] apply_op(logic [63:0] v, logic [SITE_W-1:0] site,
                                            act_type act, logic [SCNT_W-1:0] nsites);
      logic [63:0] bit_m;
      logic [63:0] nv;
      logic        fail;
      bit_m = 64'd1 << site;
      nv    = v;
      fail  = 1'b0;
      if (act != ACT_EMPTY) begin
         if ({1'b0, site} >= nsites) begin
            fail = 1'b1;
         end else if (act == ACT_ANNIH) begin
            fail = ~|(v & bit_m);
            nv   = v & ~bit_m;
         end else begin
            fail = |(v & bit_m);
            nv   = v | bit_m;
         end
      end
      return {fail, (act != ACT_EMPTY) & ^(nv & (bit_m - 64'd1)), nv};
   endfunction

endpackage

@@ sv/fermion_term_apply_lookup.sv @@
// Channel | Direction | Payload
// req     | in        | tuser: kind; tdata: occupation, source_row, site_a..d, action_a..d
// rsp     | out       | tdata: emitted, row_from, row_to, negate, appended, target_bits,
//         |           |        overflow
// csr     | in        | index 0 outside_mode, index 1 site_count
// A load's response is registered and shows in the cycle after it is taken. An apply
// reads its source row, then applies each operator slot, then reads and compares each
// stored row in a newest-first search, with one more step when no row matches; the
// single-read-port row store with its registered read sets this sequence. Synchronous,
// active-high reset clears state, row count, rsp valid, outside; sets site_count to 64.
// A waiting result stalls only the next item; req is taken when idle and output is free.
`include "fermion_term_apply_lookup_macros.svh"
module fermion_term_apply_lookup
   import fta_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,          // kind
   // occupation[63:0], source_row[73:64], site_a..d[97:74], action_a..d[105:98]
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // emitted[0], row_from[10:1], row_to[20:11], negate[21], appended[22],
   // target_bits[86:23], overflow[87]
   output logic [87:0]  rsp_tdata,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [6:0]   csr_wdata
);

   typedef enum logic [2:0] {S_IDLE, S_SRC, S_OPS, S_SCAN, S_CHK, S_DONE} state_type;

   state_type          state_ff, state_in;
   logic               outside_ff;
   logic [SCNT_W-1:0]  scount_ff;
   logic [CNT_W-1:0]   total_ff, total_in;
   logic [111:0]       item_ff;
   logic [63:0]        vec_ff, vec_in;
   logic               par_ff, par_in;
   logic [1:0]         slot_ff, slot_in;
   logic [ROW_W-1:0]   idx_ff, idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [87:0]        rsp_ff, rsp_in;
   logic [63:0]        rd_data;
   mem_req_type        mreq;
   logic [SCNT_W-1:0]  nsites;
   logic [63:0]        smask;
   logic [65:0]        op_res;
   logic [SITE_W-1:0]  cur_site;
   act_type            cur_act;
   logic               full;

   fta_row_store u_store (.clock(clock), .req(mreq), .rd_data(rd_data));

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;
   assign nsites     = (scount_ff > SCNT_W'(MAX_SITES)) ? SCNT_W'(MAX_SITES) : scount_ff;
   assign smask      = (nsites >= SCNT_W'(64)) ? '1 : ((64'd1 << nsites[5:0]) - 64'd1);
   assign full       = (total_ff == CNT_W'(MAX_ROWS));

   // Select the operator slot, last first
   always_comb begin
      cur_site = item_ff[74 + 6*slot_ff +: 6];
      cur_act  = item_ff[98 + 2*slot_ff +: 2];
   end
   assign op_res = apply_op(vec_ff, cur_site, cur_act, nsites);

   // Sequence one item through the store
   always_comb begin
      state_in     = state_ff;
      total_in     = total_ff;
      vec_in       = vec_ff;
      par_in       = par_ff;
      slot_in      = slot_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      mreq         = '0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (req_tuser == KIND_LOAD) begin
                  rsp_in = '0;
                  if (full) begin
                     rsp_in[87] = 1'b1;
                  end else begin
                     mreq.wr_en    = 1'b1;
                     mreq.wr_addr  = total_ff[ROW_W-1:0];
                     mreq.wr_data  = req_tdata[63:0] & smask;
                     rsp_in[20:11] = total_ff[ROW_W-1:0];
                     rsp_in[22]    = 1'b1;
                     rsp_in[86:23] = req_tdata[63:0] & smask;
                     total_in      = total_ff + CNT_W'(1);
                  end
                  rsp_valid_in = 1'b1;
               end else begin
                  mreq.rd_en   = 1'b1;
                  mreq.rd_addr = req_tdata[73:64];
                  state_in     = S_SRC;
               end
            end
         end
         S_SRC: begin
            vec_in  = rd_data;
            par_in  = 1'b0;
            slot_in = 2'(SLOTS - 1);
            if ({1'b0, item_ff[73:64]} >= total_ff) begin
               rsp_in       = '0;
               rsp_in[10:1] = item_ff[73:64];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               state_in = S_OPS;
            end
         end
         S_OPS: begin
            if (op_res[65]) begin
               rsp_in       = '0;
               rsp_in[10:1] = item_ff[73:64];
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               vec_in  = op_res[63:0];
               par_in  = par_ff ^ op_res[64];
               slot_in = slot_ff - 2'd1;
               if (slot_ff == 2'd0) begin
                  idx_in       = total_ff[ROW_W-1:0] - ROW_W'(1);
                  mreq.rd_en   = 1'b1;
                  mreq.rd_addr = total_ff[ROW_W-1:0] - ROW_W'(1);
                  state_in     = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Data for idx_ff arrives now; compare in S_CHK
            state_in = S_CHK;
         end
         S_CHK: begin
            rsp_in        = '0;
            rsp_in[10:1]  = item_ff[73:64];
            rsp_in[21]    = par_ff;
            rsp_in[86:23] = vec_ff;
            if (rd_data == vec_ff) begin
               rsp_in[0]     = 1'b1;
               rsp_in[20:11] = idx_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end else if (idx_ff != '0) begin
               idx_in       = idx_ff - ROW_W'(1);
               mreq.rd_en   = 1'b1;
               mreq.rd_addr = idx_ff - ROW_W'(1);
               state_in     = S_SCAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // No match: in outside mode append, or flag overflow when the store is full
            rsp_in        = '0;
            rsp_in[10:1]  = item_ff[73:64];
            rsp_in[21]    = par_ff;
            rsp_in[86:23] = vec_ff;
            if (outside_ff) begin
               if (full) begin
                  rsp_in[87] = 1'b1;
               end else begin
                  mreq.wr_en    = 1'b1;
                  mreq.wr_addr  = total_ff[ROW_W-1:0];
                  mreq.wr_data  = vec_ff;
                  rsp_in[0]     = 1'b1;
                  rsp_in[20:11] = total_ff[ROW_W-1:0];
                  rsp_in[22]    = 1'b1;
                  total_in      = total_ff + CNT_W'(1);
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold state, counters and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         outside_ff   <= 1'b0;
         scount_ff    <= SCNT_W'(64);
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_OUTSIDE) begin
               outside_ff <= csr_wdata[0];
            end else begin
               scount_ff <= csr_wdata;
            end
         end
      end
      if (req_tvalid && req_tready) begin
         item_ff <= req_tdata;
      end
      vec_ff  <= vec_in;
      par_ff  <= par_in;
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      rsp_ff  <= rsp_in;
   end

   `FTA_ASSERT_ALWAYS(a_total_bound, clock, reset, total_ff <= CNT_W'(MAX_ROWS), "row count past capacity")
   `FTA_ASSERT_NEXT(a_total_step, clock, reset, 1'b1, (total_ff == $past(total_ff)) || (total_ff == $past(total_ff) + CNT_W'(1)), "row count jumped")
   `FTA_ASSERT_ALWAYS(a_no_accept_busy, clock, reset, !(req_tready && (rsp_valid_ff || state_ff != S_IDLE)), "accepted while busy")
   `FTA_ASSERT_NEXT(a_append_grows, clock, reset, mreq.wr_en, total_ff == $past(total_ff) + CNT_W'(1), "store write without count")

endmodule

@@ sv/fta_row_store.sv @@
module fta_row_store
   import fta_pkg::*;
(
   input  logic              clock,
   input  mem_req_type       req,
   output logic [63:0]       rd_data
);

   logic [63:0] mem [MAX_ROWS];

   // Write and registered read, one port each
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         mem[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data <= mem[req.rd_addr];
      end
   end

endmodule
